@@ hdl/lpcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared constants, types and helpers for the laser pixel to point converter.
// ----------------------------------------------------------------------------
package lpcp_pkg;

    // default parameter values
    localparam int PIXEL_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // integer bits of a coordinate above the fraction
    localparam int OUT_INT_BITS = 10;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_SCAN_RADIUS  = 3'd2,
        REG_CENTER_X     = 3'd3,
        REG_CENTER_Y     = 3'd4,
        REG_CENTER_Z     = 3'd5
    } cfg_reg_t;

    localparam int RADIUS_W = 16;
    localparam int CENTER_W = 16;
    localparam int ANGLE_W  = 16;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;
    localparam int SCAN_RADIUS_RESET  = 12800;

    // dimension registers must hold the reset width
    localparam int DIM_MIN_W = 10;

    // trig values, Q16
    localparam int TRIG_ONE    = 65536;
    localparam int TRIG_W      = 18;   // signed, -1.0 .. +1.0
    localparam int TRIG_MAG_W  = 17;   // magnitude, 0 .. 1.0
    localparam int TRIG_SHIFT  = 17;   // log2 of 2 * TRIG_ONE

    // CORDIC
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_W        = 19;
    localparam int CORDIC_GAIN_INV = 39797;
    localparam int DEG100_TO_RAD   = 749613;  // rad per 0.01 deg, Q32
    localparam int RAD_K_W         = 20;
    localparam int ANGLE_RED_W     = 14;      // angle within a quadrant
    localparam int ANGLE_FULL      = 36000;
    localparam int ANGLE_QUARTER   = 9000;
    localparam int Z_ROUND         = 32768;
    localparam int Z_SHIFT         = 16;

    // per-lane sign of the final quotient
    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } neg_t;

    function automatic int dim_width(input int pixel_bits);
        return (pixel_bits + 1 > DIM_MIN_W) ? pixel_bits + 1 : DIM_MIN_W;
    endfunction

    // dividend width after the scale products and the pre-shift
    function automatic int dvd_width(input int pixel_bits);
        return dim_width(pixel_bits) + RADIUS_W + TRIG_MAG_W + 1 - TRIG_SHIFT;
    endfunction

    function automatic int cfg_width(input int pixel_bits);
        return (pixel_bits + 1 > RADIUS_W) ? pixel_bits + 1 : RADIUS_W;
    endfunction

    // arctan(2^-i) in Q16 radians
    function automatic logic [CORDIC_W-1:0] atan_q16(input int unsigned i);
        logic [CORDIC_W-1:0] v;
        case (i)
            0:       v = CORDIC_W'(51472);
            1:       v = CORDIC_W'(30386);
            2:       v = CORDIC_W'(16055);
            3:       v = CORDIC_W'(8150);
            4:       v = CORDIC_W'(4091);
            5:       v = CORDIC_W'(2047);
            6:       v = CORDIC_W'(1024);
            7:       v = CORDIC_W'(512);
            8:       v = CORDIC_W'(256);
            9:       v = CORDIC_W'(128);
            10:      v = CORDIC_W'(64);
            11:      v = CORDIC_W'(32);
            12:      v = CORDIC_W'(16);
            13:      v = CORDIC_W'(8);
            14:      v = CORDIC_W'(4);
            15:      v = CORDIC_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/laser_pixel_to_cylinder_point.sv @@
// ----------------------------------------------------------------------------
// laser_pixel_to_cylinder_point
// Maps a laser-line pixel and turntable angle to a 3-D point, fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_*): one transfer carries pixel column, pixel row and the
//   turntable angle in 0.01 degree. Result channel (m_*): one transfer per
//   input carries x, y, z in 2^-FRAC_BITS mm, saturated, in input order.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index on the
//   same edge; write only while no item is in flight. Indexes beyond the
//   register list are ignored. A zero width or height acts as one.
//   Throughput: one item per cycle while the result channel is not stalled.
//   Pipeline: 20 CORDIC stages, 4 scale stages, one divider stage per
//   quotient bit (max(PIXEL_BITS + 1, 10) + 17 bits) and one output
//   register lie between input transfer and result valid; the divider is
//   the deepest part.
//   Reset (aresetn low, synchronous): the pipeline empties and registers take
//   W = 640, H = 480, radius 12800, centres 0.
//   Stall: with m_ready low, items pile up into empty stages; s_ready drops
//   only once every stage holds an item. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module laser_pixel_to_cylinder_point #(
    parameter int PIXEL_BITS = lpcp_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = lpcp_pkg::FRAC_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    // configuration
    input  logic                                            cfg_we,
    input  logic [lpcp_pkg::CFG_INDEX_W-1:0]                cfg_index,
    input  logic [lpcp_pkg::cfg_width(PIXEL_BITS)-1:0]      cfg_wdata,
    // input channel
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [PIXEL_BITS-1:0]                           s_pixel_col,
    input  logic [PIXEL_BITS-1:0]                           s_pixel_row,
    input  logic [lpcp_pkg::ANGLE_W-1:0]                    s_turn_angle,
    // result channel
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output logic signed [FRAC_BITS+lpcp_pkg::OUT_INT_BITS-1:0] m_point_x,
    output logic signed [FRAC_BITS+lpcp_pkg::OUT_INT_BITS-1:0] m_point_y,
    output logic signed [FRAC_BITS+lpcp_pkg::OUT_INT_BITS-1:0] m_point_z
);
    import lpcp_pkg::*;

    localparam int OUT_BITS = FRAC_BITS + OUT_INT_BITS;
    localparam int DIM_W    = dim_width(PIXEL_BITS);
    localparam int DVD_W    = dvd_width(PIXEL_BITS);
    localparam int SIDE_W   = 2 * PIXEL_BITS;
    // signed quotient plus centre, wider than the output at the default parameters
    localparam int SUM_W    = DVD_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // configuration registers
    logic [DIM_W-1:0]           width_reg, height_reg;
    logic [RADIUS_W-1:0]        radius_reg;
    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [DIM_W-1:0]           w_eff, h_eff;

    // CORDIC -> scale
    logic                     cor_valid, cor_ready;
    logic signed [TRIG_W-1:0] cor_cos, cor_sin;
    logic [SIDE_W-1:0]        cor_side;

    // scale -> divider
    logic             scl_valid, scl_ready;
    logic [DVD_W-1:0] scl_dvd_x, scl_dvd_y, scl_dvd_z;
    neg_t             scl_neg;

    // divider -> output register
    logic             div_valid, div_ready;
    logic [DVD_W-1:0] div_quo_x, div_quo_y, div_quo_z;
    neg_t             div_neg;

    // output register
    logic                       m_valid_reg;
    logic signed [OUT_BITS-1:0] px_reg, py_reg, pz_reg;
    logic                       out_rdy;

    // register file; only the low PIXEL_BITS+1 bits of a dimension are kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(IMAGE_WIDTH_RESET);
            height_reg   <= DIM_W'(IMAGE_HEIGHT_RESET);
            radius_reg   <= RADIUS_W'(SCAN_RADIUS_RESET);
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg    <= DIM_W'(cfg_wdata[PIXEL_BITS:0]);
                REG_IMAGE_HEIGHT: height_reg   <= DIM_W'(cfg_wdata[PIXEL_BITS:0]);
                REG_SCAN_RADIUS:  radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                REG_CENTER_X:     center_x_reg <= signed'(cfg_wdata[CENTER_W-1:0]);
                REG_CENTER_Y:     center_y_reg <= signed'(cfg_wdata[CENTER_W-1:0]);
                REG_CENTER_Z:     center_z_reg <= signed'(cfg_wdata[CENTER_W-1:0]);
                default: ;
            endcase
        end
    end

    // zero dimension behaves as one
    assign w_eff = (width_reg  == '0) ? DIM_W'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;

    // angle -> cos, sin; pixel coordinates ride along
    lpcp_cordic #(
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_angle  (s_turn_angle),
        .in_side   ({s_pixel_row, s_pixel_col}),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin),
        .out_side  (cor_side)
    );

    // offsets, radius scale, trig products, rounding offsets
    lpcp_scale #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cor_valid),
        .in_ready    (cor_ready),
        .in_col      (cor_side[PIXEL_BITS-1:0]),
        .in_row      (cor_side[SIDE_W-1:PIXEL_BITS]),
        .in_cos      (cor_cos),
        .in_sin      (cor_sin),
        .dim_w       (w_eff),
        .dim_h       (h_eff),
        .scan_radius (radius_reg),
        .out_valid   (scl_valid),
        .out_ready   (scl_ready),
        .out_dvd_x   (scl_dvd_x),
        .out_dvd_y   (scl_dvd_y),
        .out_dvd_z   (scl_dvd_z),
        .out_neg     (scl_neg)
    );

    // divide by W (x, z) and H (y)
    lpcp_div #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_dvd_x  (scl_dvd_x),
        .in_dvd_y  (scl_dvd_y),
        .in_dvd_z  (scl_dvd_z),
        .in_neg    (scl_neg),
        .dim_w     (w_eff),
        .dim_h     (h_eff),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quo_x (div_quo_x),
        .out_quo_y (div_quo_y),
        .out_quo_z (div_quo_z),
        .out_neg   (div_neg)
    );

    // apply sign, add the centre, clip to the output range
    function automatic logic signed [OUT_BITS-1:0] place(
        input logic [DVD_W-1:0]           q,
        input logic                       neg,
        input logic signed [CENTER_W-1:0] ctr
    );
        logic signed [SUM_W-1:0] qs, cs, sum;
        logic signed [OUT_BITS-1:0] r;
        qs  = signed'({2'b00, q});
        cs  = SUM_W'(ctr);
        sum = neg ? cs - qs : cs + qs;
        if (sum > SAT_HI) begin
            r = OUT_BITS'(SAT_HI);
        end else if (sum < SAT_LO) begin
            r = OUT_BITS'(SAT_LO);
        end else begin
            r = OUT_BITS'(sum);
        end
        return r;
    endfunction

    // output register parts the divider from the receiver
    assign out_rdy   = !m_valid_reg || m_ready;
    assign div_ready = out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            px_reg <= place(div_quo_x, div_neg.x, center_x_reg);
            py_reg <= place(div_quo_y, div_neg.y, center_y_reg);
            pz_reg <= place(div_quo_z, div_neg.z, center_z_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = px_reg;
    assign m_point_y = py_reg;
    assign m_point_z = pz_reg;

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_eff != '0) && (h_eff != '0))
        else $error("effective image dimension is zero");

    a_result_from_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(div_valid))
        else $error("result appeared without a divider transfer");

    a_no_drop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_ready) |-> m_valid_reg)
        else $error("divider held off while output register empty");

endmodule

@@ hdl/lpcp_cordic.sv @@
// ----------------------------------------------------------------------------
// lpcp_cordic
// Pipelined angle reduction and rotation CORDIC giving Q16 cos and sin.
// ----------------------------------------------------------------------------
module lpcp_cordic #(
    parameter int SIDE_W = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [lpcp_pkg::ANGLE_W-1:0]             in_angle,
    input  logic [SIDE_W-1:0]                        in_side,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [lpcp_pkg::TRIG_W-1:0]       out_cos,
    output logic signed [lpcp_pkg::TRIG_W-1:0]       out_sin,
    output logic [SIDE_W-1:0]                        out_side
);
    import lpcp_pkg::*;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    // reduce, multiply, z init, steps, clamp/quadrant
    localparam int NS       = CORDIC_STEPS + 4;
    localparam int ST_MUL   = 1;
    localparam int ST_ZINIT = 2;
    localparam int ST_POST  = NS - 1;
    localparam int PROD_W   = ANGLE_RED_W + RAD_K_W;
    localparam int ZSUM_W   = PROD_W + 1;

    localparam logic signed [CORDIC_W-1:0] ONE_C    = CORDIC_W'(TRIG_ONE);
    localparam logic signed [TRIG_W-1:0]   TRIG_POS = TRIG_W'(TRIG_ONE);
    localparam logic signed [TRIG_W-1:0]   TRIG_NEG = -TRIG_POS;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    logic [ANGLE_RED_W-1:0]     u_reg;
    logic [PROD_W-1:0]          prod_reg;
    quad_t                      quad_reg [NS-1];
    logic [SIDE_W-1:0]          side_reg [NS];
    logic signed [CORDIC_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cz_reg [CORDIC_STEPS];
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W-1:0]   sin_reg;

    logic [ANGLE_W-1:0]         ang_mod;
    logic [ANGLE_RED_W-1:0]     u_next;
    quad_t                      quad_next;
    logic [ZSUM_W-1:0]          zsum;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [TRIG_W-1:0]   bc, bs, cos_next, sin_next;

    // ready travels back stage by stage; bubbles collapse
    assign rdy[NS] = out_ready;
    for (genvar gi = 0; gi < NS; gi++) begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // wrap to one turn, then split off the quadrant
    always_comb begin
        ang_mod = (in_angle >= ANGLE_W'(ANGLE_FULL)) ? in_angle - ANGLE_W'(ANGLE_FULL)
                                                     : in_angle;
        if (ang_mod < ANGLE_W'(ANGLE_QUARTER)) begin
            quad_next = QUAD_0;
            u_next    = ANGLE_RED_W'(ang_mod);
        end else if (ang_mod < ANGLE_W'(2 * ANGLE_QUARTER)) begin
            quad_next = QUAD_1;
            u_next    = ANGLE_RED_W'(ang_mod - ANGLE_W'(ANGLE_QUARTER));
        end else if (ang_mod < ANGLE_W'(3 * ANGLE_QUARTER)) begin
            quad_next = QUAD_2;
            u_next    = ANGLE_RED_W'(ang_mod - ANGLE_W'(2 * ANGLE_QUARTER));
        end else begin
            quad_next = QUAD_3;
            u_next    = ANGLE_RED_W'(ang_mod - ANGLE_W'(3 * ANGLE_QUARTER));
        end
    end

    // radians, Q16, rounded
    always_comb begin
        zsum   = {1'b0, prod_reg} + ZSUM_W'(Z_ROUND);
        z_init = signed'(zsum[Z_SHIFT +: CORDIC_W]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            u_reg       <= u_next;
            quad_reg[0] <= quad_next;
            side_reg[0] <= in_side;
        end
        if (rdy[ST_MUL]) begin
            prod_reg <= PROD_W'(u_reg) * PROD_W'(DEG100_TO_RAD);
        end
        if (rdy[ST_ZINIT]) begin
            cx_reg[0] <= CORDIC_W'(CORDIC_GAIN_INV);
            cy_reg[0] <= '0;
            cz_reg[0] <= z_init;
        end
        for (int i = 1; i < NS - 1; i++) begin
            if (rdy[i]) begin
                quad_reg[i] <= quad_reg[i-1];
            end
        end
        for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (rdy[ST_POST]) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CORDIC_W-1:0] dx, dy, atan_k;
        assign dx     = cy_reg[k] >>> k;
        assign dy     = cx_reg[k] >>> k;
        assign atan_k = signed'(atan_q16(k));

        always_ff @(posedge aclk) begin
            if (rdy[ST_ZINIT+1+k]) begin
                if (!cz_reg[k][CORDIC_W-1]) begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                end else begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                end
            end
        end

        if (k < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (rdy[ST_ZINIT+1+k]) begin
                    cz_reg[k+1] <= cz_reg[k][CORDIC_W-1] ? cz_reg[k] + atan_k
                                                          : cz_reg[k] - atan_k;
                end
            end
        end
    end

    function automatic logic signed [TRIG_W-1:0] clamp_trig(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [TRIG_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_C) begin
            r = TRIG_POS;
        end else begin
            r = TRIG_W'(v);
        end
        return r;
    endfunction

    always_comb begin
        bc = clamp_trig(cx_reg[CORDIC_STEPS]);
        bs = clamp_trig(cy_reg[CORDIC_STEPS]);
        case (quad_reg[NS-2])
            QUAD_0: begin
                cos_next = bc;
                sin_next = bs;
            end
            QUAD_1: begin
                cos_next = -bs;
                sin_next = bc;
            end
            QUAD_2: begin
                cos_next = -bc;
                sin_next = -bs;
            end
            default: begin
                cos_next = bs;
                sin_next = -bc;
            end
        endcase
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = side_reg[NS-1];

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_cos >= TRIG_NEG && out_cos <= TRIG_POS &&
                       out_sin >= TRIG_NEG && out_sin <= TRIG_POS))
        else $error("cos/sin outside unit range");

endmodule

@@ hdl/lpcp_scale.sv @@
// ----------------------------------------------------------------------------
// lpcp_scale
// Pixel offsets, radius scaling and trig products; forms the dividends.
// ----------------------------------------------------------------------------
module lpcp_scale #(
    parameter int PIXEL_BITS = lpcp_pkg::PIXEL_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [PIXEL_BITS-1:0]                          in_col,
    input  logic [PIXEL_BITS-1:0]                          in_row,
    input  logic signed [lpcp_pkg::TRIG_W-1:0]             in_cos,
    input  logic signed [lpcp_pkg::TRIG_W-1:0]             in_sin,
    input  logic [lpcp_pkg::dim_width(PIXEL_BITS)-1:0]     dim_w,
    input  logic [lpcp_pkg::dim_width(PIXEL_BITS)-1:0]     dim_h,
    input  logic [lpcp_pkg::RADIUS_W-1:0]                  scan_radius,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_dvd_x,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_dvd_y,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_dvd_z,
    output lpcp_pkg::neg_t                                 out_neg
);
    import lpcp_pkg::*;

    localparam int NS     = 4;
    localparam int DIM_W  = dim_width(PIXEL_BITS);
    localparam int DIFF_W = DIM_W + 1;
    localparam int RN_W   = DIM_W + RADIUS_W;
    localparam int MP_W   = RN_W + TRIG_MAG_W;
    localparam int DVD_W  = dvd_width(PIXEL_BITS);

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    // stage 0
    logic [DIM_W-1:0]      mc0_reg, mr0_reg;
    logic [TRIG_MAG_W-1:0] tc0_reg, ts0_reg;
    neg_t                  neg0_reg;
    // stage 1
    logic [RN_W-1:0]       rx1_reg, ry1_reg;
    logic [TRIG_MAG_W-1:0] tc1_reg, ts1_reg;
    neg_t                  neg1_reg;
    // stage 2
    logic [MP_W-1:0]       px2_reg, pz2_reg;
    logic [RN_W-1:0]       dy2_reg;
    neg_t                  neg2_reg;
    // stage 3
    logic [DVD_W-1:0]      dx3_reg, dy3_reg, dz3_reg;
    neg_t                  neg3_reg;

    logic signed [DIFF_W-1:0] dc, dr;
    logic [DIFF_W-1:0]        dc_abs, dr_abs;
    logic [TRIG_W-1:0]        c_abs, s_abs;
    neg_t                     neg0_next;
    logic [RN_W:0]            ysum;
    logic [MP_W:0]            xsum, zsum, half_w;

    assign rdy[NS] = out_ready;
    for (genvar gi = 0; gi < NS; gi++) begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // offsets from the image centre, doubled to stay integer
    always_comb begin
        dc = signed'({1'b0, DIM_W'({in_col, 1'b0})}) - signed'({1'b0, dim_w});
        dr = signed'({1'b0, DIM_W'({in_row, 1'b0})}) - signed'({1'b0, dim_h});
        dc_abs = dc[DIFF_W-1] ? -dc : dc;
        dr_abs = dr[DIFF_W-1] ? -dr : dr;
        c_abs  = in_cos[TRIG_W-1] ? -in_cos : in_cos;
        s_abs  = in_sin[TRIG_W-1] ? -in_sin : in_sin;
        neg0_next.x = dc[DIFF_W-1] ^ in_cos[TRIG_W-1];
        neg0_next.z = dc[DIFF_W-1] ^ in_sin[TRIG_W-1];
        // height points up: negative when the row lies below the centre
        neg0_next.y = !dr[DIFF_W-1];
    end

    // round to nearest: add half the divisor, drop the power-of-two part
    always_comb begin
        ysum   = {1'b0, ry1_reg} + (RN_W+1)'(dim_h);
        half_w = (MP_W+1)'(dim_w) << (TRIG_SHIFT - 1);
        xsum   = {1'b0, px2_reg} + half_w;
        zsum   = {1'b0, pz2_reg} + half_w;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            mc0_reg  <= dc_abs[DIM_W-1:0];
            mr0_reg  <= dr_abs[DIM_W-1:0];
            tc0_reg  <= c_abs[TRIG_MAG_W-1:0];
            ts0_reg  <= s_abs[TRIG_MAG_W-1:0];
            neg0_reg <= neg0_next;
        end
        if (rdy[1]) begin
            rx1_reg  <= RN_W'(mc0_reg) * RN_W'(scan_radius);
            ry1_reg  <= RN_W'(mr0_reg) * RN_W'(scan_radius);
            tc1_reg  <= tc0_reg;
            ts1_reg  <= ts0_reg;
            neg1_reg <= neg0_reg;
        end
        if (rdy[2]) begin
            px2_reg  <= MP_W'(rx1_reg) * MP_W'(tc1_reg);
            pz2_reg  <= MP_W'(rx1_reg) * MP_W'(ts1_reg);
            dy2_reg  <= ysum[RN_W:1];
            neg2_reg <= neg1_reg;
        end
        if (rdy[3]) begin
            dx3_reg  <= xsum[MP_W:TRIG_SHIFT];
            dz3_reg  <= zsum[MP_W:TRIG_SHIFT];
            dy3_reg  <= DVD_W'(dy2_reg);
            neg3_reg <= neg2_reg;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_dvd_x = dx3_reg;
    assign out_dvd_y = dy3_reg;
    assign out_dvd_z = dz3_reg;
    assign out_neg   = neg3_reg;

endmodule

@@ hdl/lpcp_div.sv @@
// ----------------------------------------------------------------------------
// lpcp_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lpcp_div #(
    parameter int PIXEL_BITS = lpcp_pkg::PIXEL_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     in_dvd_x,
    input  logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     in_dvd_y,
    input  logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     in_dvd_z,
    input  lpcp_pkg::neg_t                                 in_neg,
    input  logic [lpcp_pkg::dim_width(PIXEL_BITS)-1:0]     dim_w,
    input  logic [lpcp_pkg::dim_width(PIXEL_BITS)-1:0]     dim_h,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_quo_x,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_quo_y,
    output logic [lpcp_pkg::dvd_width(PIXEL_BITS)-1:0]     out_quo_z,
    output lpcp_pkg::neg_t                                 out_neg
);
    import lpcp_pkg::*;

    localparam int DIM_W = dim_width(PIXEL_BITS);
    localparam int DVD_W = dvd_width(PIXEL_BITS);
    localparam int NS    = DVD_W;
    localparam int ACC_W = DIM_W + DVD_W;
    localparam int LANES = 3;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    // acc = {remainder, dividend bits left | quotient bits so far}
    logic [ACC_W-1:0] acc_reg  [NS][LANES];
    neg_t             neg_reg  [NS];
    logic [ACC_W-1:0] step_out [NS][LANES];
    logic [ACC_W-1:0] acc_in   [LANES];
    logic [DIM_W-1:0] dvs      [LANES];

    assign dvs[0] = dim_w;
    assign dvs[1] = dim_h;
    assign dvs[2] = dim_w;

    assign acc_in[0] = {{DIM_W{1'b0}}, in_dvd_x};
    assign acc_in[1] = {{DIM_W{1'b0}}, in_dvd_y};
    assign acc_in[2] = {{DIM_W{1'b0}}, in_dvd_z};

    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0] acc,
        input logic [DIM_W-1:0] d
    );
        logic [DIM_W:0] part;
        logic [DIM_W:0] rem;
        logic           ge;
        part = {acc[ACC_W-1 -: DIM_W], acc[DVD_W-1]};
        ge   = (part >= {1'b0, d});
        rem  = ge ? part - {1'b0, d} : part;
        return {rem[DIM_W-1:0], acc[DVD_W-2:0], ge};
    endfunction

    assign rdy[NS] = out_ready;
    for (genvar gi = 0; gi < NS; gi++) begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            step_out[0][l] = div_step(acc_in[l], dvs[l]);
            for (int s = 1; s < NS; s++) begin
                step_out[s][l] = div_step(acc_reg[s-1][l], dvs[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            acc_reg[0] <= step_out[0];
            neg_reg[0] <= in_neg;
        end
        for (int s = 1; s < NS; s++) begin
            if (rdy[s]) begin
                acc_reg[s] <= step_out[s];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_quo_x = acc_reg[NS-1][0][DVD_W-1:0];
    assign out_quo_y = acc_reg[NS-1][1][DVD_W-1:0];
    assign out_quo_z = acc_reg[NS-1][2][DVD_W-1:0];
    assign out_neg   = neg_reg[NS-1];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (acc_reg[NS-1][0][ACC_W-1 -: DIM_W] < dim_w &&
                       acc_reg[NS-1][1][ACC_W-1 -: DIM_W] < dim_h &&
                       acc_reg[NS-1][2][ACC_W-1 -: DIM_W] < dim_w))
        else $error("divider remainder not below divisor");

endmodule
